// ----- rtl/dfl_box_score_decode_macros.svh -----
// Assertion macros for the box and score decoder.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef DFL_BOX_SCORE_DECODE_MACROS_SVH
`define DFL_BOX_SCORE_DECODE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DBSD_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error("dbsd check failed");
`define DBSD_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) (ante) |-> (cons)) else $error("dbsd check failed");
`else
`define DBSD_ASSERT(lbl, prop)
`define DBSD_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- rtl/dbsd_pkg.sv -----
// Shared types, constants and the exponential table builder of the decoder.
// No dependencies.
package dbsd_pkg;

  localparam int LogitW = 16;
  localparam int CellW  = 9;
  localparam int DistW  = 16;
  localparam int WghtW  = 17;

  typedef struct packed {
    logic                     is_class;
    logic signed [LogitW-1:0] logit;
    logic [1:0]               side;
    logic [CellW-1:0]         cell_x;
    logic [CellW-1:0]         cell_y;
    logic [1:0]               level;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAX, ST_WGT, ST_DRN, ST_CLS, ST_DIV, ST_FIN, ST_BOX
  } bk_state_e;

  localparam logic [1:0] SideBottom = 2'd3;
  localparam logic       ActBox     = 1'b0;

  // Entry k of the e^-t table in Q16, built by the Q32 recurrence.
  function automatic logic [WghtW-1:0] exp_entry(int k, logic [63:0] step);
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] v;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step) >> 32) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = 128'd1 << 32;
    for (int j = 0; j < k; j++) begin
      v = (v * 128'(sum) + (128'd1 << 31)) >> 32;
    end
    return WghtW'((v + 128'd32768) >> 16);
  endfunction

endpackage

// ----- rtl/dbsd_if.sv -----
// Valid/ready channel interfaces for input words and result words.
// Depends on nothing but the field widths written here.
interface dbsd_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [1:0]         side;
  logic [3:0]         bin;
  logic signed [15:0] logit;
  logic [8:0]         cell_x;
  logic [8:0]         cell_y;
  logic [1:0]         level;
  modport source (output valid, action, side, bin, logit, cell_x, cell_y, level, input ready);
  modport sink (input valid, action, side, bin, logit, cell_x, cell_y, level, output ready);
endinterface

interface dbsd_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [19:0] center_x;
  logic signed [19:0] center_y;
  logic [18:0]        box_width;
  logic [18:0]        box_height;
  logic [15:0]        score;
  modport source (output valid, kind, center_x, center_y, box_width, box_height, score,
                  input ready);
  modport sink (input valid, kind, center_x, center_y, box_width, box_height, score,
                output ready);
endinterface

// ----- rtl/dbsd_front.sv -----
// Front end: accepts input words, buffers bin logits and queues jobs.
// Depends on dbsd_pkg and dbsd_in_if.
module dbsd_front #(
  parameter int BINS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dbsd_in_if.sink                         in_i,
  input  logic                            full_i,
  input  logic                            lock_clr_i,
  input  logic [$clog2(BINS)-1:0]         rd_idx_i,
  output logic signed [dbsd_pkg::LogitW-1:0] rd_data_o,
  output logic                            push_o,
  output dbsd_pkg::job_t                  job_o
);
  import dbsd_pkg::*;

  localparam int BW = $clog2(BINS);

  logic signed [LogitW-1:0] bl_q [BINS];
  logic                     lock_q, lock_d;
  logic                     acc, in_range, last_bin;

  // A box word waits while the back end still reads the buffer.
  assign in_i.ready = !full_i && !(in_i.action == ActBox && lock_q);
  assign acc        = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.bin) < BINS;
  assign last_bin   = 32'(in_i.bin) == BINS - 1;
  assign push_o     = acc && (in_i.action != ActBox || last_bin);

  assign job_o.is_class = in_i.action != ActBox;
  assign job_o.logit    = in_i.logit;
  assign job_o.side     = in_i.side;
  assign job_o.cell_x   = in_i.cell_x;
  assign job_o.cell_y   = in_i.cell_y;
  assign job_o.level    = in_i.level;

  assign rd_data_o = bl_q[rd_idx_i];

  // Logit buffer write.
  always_ff @(posedge clk_i) begin
    if (acc && in_i.action == ActBox && in_range) begin
      bl_q[BW'(in_i.bin)] <= in_i.logit;
    end
  end

  // The lock covers the time the back end walks the buffer.
  always_comb begin
    lock_d = lock_q;
    if (lock_clr_i) begin
      lock_d = 1'b0;
    end
    if (acc && in_i.action == ActBox && last_bin) begin
      lock_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b0;
    end else begin
      lock_q <= lock_d;
    end
  end
endmodule

// ----- rtl/dbsd_queue.sv -----
// Two-entry job queue between the front and back ends.
// Depends on dbsd_pkg.
module dbsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dbsd_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output dbsd_pkg::job_t job_o
);
  import dbsd_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ----- rtl/dbsd_back.sv -----
// Back end: softmax walk, shared radix-2 divider, box geometry and output register.
// Depends on dbsd_pkg, dbsd_out_if and the assertion macros.
`include "dfl_box_score_decode_macros.svh"
module dbsd_back #(
  parameter int BINS            = 16,
  parameter int GRID_MAX        = 512,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  dbsd_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               lock_clr_o,
  output logic [$clog2(BINS)-1:0]            rd_idx_o,
  input  logic signed [dbsd_pkg::LogitW-1:0] rd_data_i,
  dbsd_out_if.source                         out_o
);
  import dbsd_pkg::*;

  localparam int BW   = $clog2(BINS);
  localparam int IW   = $clog2(EXP_TABLE_DEPTH);
  localparam int DENW = WghtW + BW;
  localparam int NUMW = WghtW + 2 * BW;
  localparam int DVDW = (NUMW + 9 > 34) ? NUMW + 9 : 34;
  localparam int DSW  = (DENW > 18) ? DENW : 18;
  localparam int DCW  = $clog2(DVDW);
  localparam logic [63:0] ExpStep = (64'd16 << 32) / EXP_TABLE_DEPTH;

  // Constant e^-t table.
  logic [WghtW-1:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [WghtW-1:0] Entry = exp_entry(k, ExpStep);
    assign exp_tab[k] = Entry;
  end

  bk_state_e st_q, st_d;
  job_t      job_q;
  logic [BW-1:0]            cnt_q;
  logic signed [LogitW-1:0] m_q;
  logic [WghtW-1:0]         w_q;
  logic [BW-1:0]            wi_q;
  logic                     wv_q;
  logic [NUMW-1:0]          num_q;
  logic [DENW-1:0]          den_q;
  logic [DVDW-1:0]          dvd_q;
  logic [DSW:0]             rem_q;
  logic [DSW-1:0]           dsr_q;
  logic [DCW-1:0]           dcnt_q;
  logic [DistW-1:0]         dist_q [4];
  logic                     ov_q;
  logic                     kind_q;
  logic signed [19:0]       cx_q, cy_q;
  logic [18:0]              bw_q, bh_q;
  logic [15:0]              score_q;

  logic                     free, out_ld, last_cnt, div_done;
  logic [16:0]              lk_d;
  logic [IW+12:0]           lk_prod;
  logic [WghtW-1:0]         lk_w;
  logic signed [16:0]       diff;
  logic [16:0]              cls_abs;
  logic [17:0]              cls_den;
  logic [DSW:0]             rem_sh;
  logic                     qbit;
  logic [NUMW-1:0]          num_fin;
  logic [DENW-1:0]          den_fin;

  assign free     = !ov_q || out_o.ready;
  assign last_cnt = cnt_q == BW'(BINS - 1);
  assign div_done = dcnt_q == DCW'(DVDW - 1);
  assign rd_idx_o = cnt_q;

  // Table lookup, shared by the weight walk and the sigmoid.
  assign diff    = 17'(m_q) - 17'(rd_data_i);
  assign cls_abs = job_q.logit[LogitW-1] ? 17'(-17'(job_q.logit)) : 17'(job_q.logit);
  assign lk_d    = (st_q == ST_CLS) ? cls_abs : 17'(diff);
  assign lk_prod = (IW+13)'(lk_d[11:0]) * (IW+13)'(EXP_TABLE_DEPTH);
  assign lk_w    = (lk_d >= 17'd4096) ? '0 : exp_tab[lk_prod[IW+11:12]];
  assign cls_den = 18'd65536 + 18'(lk_w);

  // Running sums including the weight held in the pipeline register.
  assign num_fin = num_q + NUMW'(wi_q) * NUMW'(w_q);
  assign den_fin = den_q + DENW'(w_q);

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_q[DSW-1:0], dvd_q[DVDW-1]};
    qbit   = rem_sh >= {1'b0, dsr_q};
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (!empty_i) st_d = job_i.is_class ? ST_CLS : ST_MAX;
      ST_MAX:  if (last_cnt) st_d = ST_WGT;
      ST_WGT:  if (last_cnt) st_d = ST_DRN;
      ST_DRN:  st_d = ST_DIV;
      ST_CLS:  st_d = ST_DIV;
      ST_DIV:  if (div_done) st_d = ST_FIN;
      ST_FIN: begin
        if (job_q.is_class) begin
          if (free) st_d = ST_IDLE;
        end else begin
          st_d = (job_q.side == SideBottom) ? ST_BOX : ST_IDLE;
        end
      end
      ST_BOX:  if (free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o      = (st_q == ST_IDLE) && !empty_i;
    lock_clr_o = st_q == ST_DRN;
    out_ld     = ((st_q == ST_FIN) && job_q.is_class && free) || ((st_q == ST_BOX) && free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
      for (int i = 0; i < 4; i++) dist_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (out_ld) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (st_q == ST_FIN && !job_q.is_class) begin
        dist_q[job_q.side] <= dvd_q[DistW-1:0];
      end
    end
  end

  // Box geometry from the stored distances.
  function automatic logic signed [19:0] sat_s20(logic signed [27:0] v);
    if (v > 28'sd524287) return 20'sd524287;
    if (v < -28'sd524288) return -20'sd524288;
    return 20'(v);
  endfunction

  logic [2:0]         sh;
  logic [CellW-1:0]   cxs, cys;
  logic signed [21:0] gx, gy;
  logic signed [27:0] gxm, gym;
  logic [21:0]        wm, hm;

  always_comb begin
    case (job_q.level)
      2'd0:    sh = 3'd3;
      2'd1:    sh = 3'd4;
      default: sh = 3'd5;
    endcase
    cxs = (32'(job_q.cell_x) >= GRID_MAX) ? CellW'(GRID_MAX - 1) : job_q.cell_x;
    cys = (32'(job_q.cell_y) >= GRID_MAX) ? CellW'(GRID_MAX - 1) : job_q.cell_y;
    gx  = 22'({cxs, 9'd0}) + 22'sd256 + 22'(dist_q[2]) - 22'(dist_q[0]);
    gy  = 22'({cys, 9'd0}) + 22'sd256 + 22'(dist_q[3]) - 22'(dist_q[1]);
    gxm = ((28'(gx) <<< sh) + 28'sd16) >>> 5;
    gym = ((28'(gy) <<< sh) + 28'sd16) >>> 5;
    wm  = ((22'(dist_q[0]) + 22'(dist_q[2])) << sh) + 22'd8;
    hm  = ((22'(dist_q[1]) + 22'(dist_q[3])) << sh) + 22'd8;
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      cnt_q <= '0;
    end
    case (st_q)
      ST_MAX: begin
        if (cnt_q == '0 || rd_data_i > m_q) m_q <= rd_data_i;
        cnt_q <= last_cnt ? '0 : cnt_q + 1'b1;
        num_q <= '0;
        den_q <= '0;
        wv_q  <= 1'b0;
      end
      ST_WGT, ST_DRN: begin
        if (wv_q) begin
          num_q <= num_fin;
          den_q <= den_fin;
        end
        w_q   <= lk_w;
        wi_q  <= cnt_q;
        wv_q  <= st_q == ST_WGT;
        cnt_q <= last_cnt ? '0 : cnt_q + 1'b1;
        // The last bin's weight is still in flight here, so the sums include it.
        if (st_q == ST_DRN) begin
          dvd_q  <= (DVDW'(num_fin) << 8) + DVDW'(den_fin[DENW-1:1]);
          dsr_q  <= DSW'(den_fin);
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      ST_CLS: begin
        if (job_q.logit[LogitW-1]) begin
          dvd_q <= (DVDW'(lk_w) << 16) + DVDW'(cls_den[17:1]);
        end else begin
          dvd_q <= (DVDW'(1) << 32) + DVDW'(cls_den[17:1]);
        end
        dsr_q  <= DSW'(cls_den);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= qbit ? rem_sh - {1'b0, dsr_q} : rem_sh;
        dvd_q  <= {dvd_q[DVDW-2:0], qbit};
        dcnt_q <= dcnt_q + 1'b1;
      end
      default: ;
    endcase
    if (out_ld) begin
      kind_q <= job_q.is_class;
      if (st_q == ST_BOX) begin
        cx_q    <= sat_s20(gxm);
        cy_q    <= sat_s20(gym);
        bw_q    <= 19'(wm >> 4);
        bh_q    <= 19'(hm >> 4);
        score_q <= '0;
      end else begin
        cx_q    <= '0;
        cy_q    <= '0;
        bw_q    <= '0;
        bh_q    <= '0;
        score_q <= (dvd_q > DVDW'(16'hFFFF)) ? 16'hFFFF : dvd_q[15:0];
      end
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = kind_q;
  assign out_o.center_x   = cx_q;
  assign out_o.center_y   = cy_q;
  assign out_o.box_width  = bw_q;
  assign out_o.box_height = bh_q;
  assign out_o.score      = score_q;

  `DBSD_ASSERT_IMP(a_ld_free, out_ld, !ov_q || out_o.ready)
  `DBSD_ASSERT_IMP(a_pop_idle, pop_o, st_q == ST_IDLE && !empty_i)
  `DBSD_ASSERT_IMP(a_div_nz, st_q == ST_DIV, dsr_q != '0)
  `DBSD_ASSERT_IMP(a_clr_side, lock_clr_o, !job_q.is_class)
endmodule

// ----- rtl/dfl_box_score_decode.sv -----
// Top level of the distribution box and class score decoder.
// Depends on dbsd_pkg, dbsd_if, dbsd_front, dbsd_queue and dbsd_back.
//
// Input words arrive on in_i (valid/ready); result words leave on out_o.
// A box word with a bin below the last only lands in the bin buffer and
// yields nothing. The last bin of a side queues a side job; the back end
// walks the bins twice (maximum, then weights), then runs the shared
// radix-2 divider and stores the distance. Side 3 then computes the box
// geometry and emits the box word. A class word also runs through the
// divider. Box words of the next side are held off while the side job
// waits and the back end reads the bin buffer; class words queue meanwhile.
// Reset clears the queue, the stored side distances and the output valid flag.
// When the receiver stalls, the result holds in the output register and the
// two-entry queue fills before the input side is stalled.
module dfl_box_score_decode #(
  parameter int BINS            = 16,
  parameter int GRID_MAX        = 512,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbsd_in_if.sink     in_i,
  dbsd_out_if.source  out_o
);
  import dbsd_pkg::*;

  logic                     push, pop, full, empty, lock_clr;
  job_t                     fr_job, q_job;
  logic [$clog2(BINS)-1:0]  rd_idx;
  logic signed [LogitW-1:0] rd_data;

  dbsd_front #(.BINS(BINS)) u_front (
    .clk_i, .rst_ni, .in_i,
    .full_i(full), .lock_clr_i(lock_clr), .rd_idx_i(rd_idx), .rd_data_o(rd_data),
    .push_o(push), .job_o(fr_job)
  );

  dbsd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fr_job), .pop_i(pop),
    .full_o(full), .empty_o(empty), .job_o(q_job)
  );

  dbsd_back #(
    .BINS(BINS), .GRID_MAX(GRID_MAX), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(q_job), .pop_o(pop),
    .lock_clr_o(lock_clr), .rd_idx_o(rd_idx), .rd_data_i(rd_data), .out_o
  );
endmodule
